FILE: src/krid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyed roster with id allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package krid_pkg;

	localparam int ADDR_W  = 48;
	localparam int ID_W    = 8;
	localparam int ENTRY_W = ADDR_W + ID_W;

	// Command operation codes.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Register map: register index taken from paddr[2].
	localparam logic       REG_ID_BASE   = 1'b0;
	localparam logic [7:0] ID_BASE_RESET = 8'd16;

	typedef struct packed {
		logic [1:0]        operation;
		logic [ADDR_W-1:0] device_address;
		logic [2:0]        slot_select;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   assigned_id;
		logic [2:0]        slot_used;
		logic              newly_added;
		logic              entry_present;
		logic [ADDR_W-1:0] entry_address;
		logic [3:0]        entry_count;
	} out_item_t;

	// How a command ends; selects the table update and the result fields.
	typedef enum logic [2:0] {
		FK_ADD_UPD,
		FK_ADD_NEW,
		FK_FULL,
		FK_REM_OK,
		FK_REM_NF,
		FK_CLEAR,
		FK_READ
	} fin_kind_t;

	typedef struct packed {
		logic      sweep_start;
		logic      cand_init;
		logic      cand_inc;
		logic      finish;
		fin_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic match;
		logic free;
		logic taken;
		logic cand_max;
		logic base_zero;
	} dp_status_t;

endpackage

FILE: src/krid_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module krid_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/krid_ctrl.sv
`timescale 1ns / 1ps
// Controller for the keyed roster: sequences sweeps, id retries and results.
// Depends on krid_pkg; drives the datapath through dp_cmd_t.
module krid_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [1:0]           op_in,
	input  krid_pkg::dp_status_t stat,
	output krid_pkg::dp_cmd_t    cmd,
	output logic                 busy
);
	import krid_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		SWEEP,
		RD,
		FIN
	} state_t;

	state_t  state_q;
	dp_cmd_t cmd_q;
	logic    busy_q;
	logic    add_q;

	assign cmd  = cmd_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cmd_q   <= '0;
			busy_q  <= 1'b0;
			add_q   <= 1'b0;
		end else begin
			cmd_q <= '0;
			unique case (state_q)
				IDLE: begin
					if (take) begin
						busy_q <= 1'b1;
						add_q  <= (op_in == OP_ADD);
						unique case (op_in) inside
							OP_ADD, OP_REMOVE: begin
								cmd_q.sweep_start <= 1'b1;
								cmd_q.cand_init   <= 1'b1;
								state_q           <= SWEEP;
							end
							OP_CLEAR: begin
								cmd_q.finish <= 1'b1;
								cmd_q.kind   <= FK_CLEAR;
								state_q      <= FIN;
							end
							default: begin
								state_q <= RD;
							end
						endcase
					end
				end
				RD: begin
					// Read data for the selected slot is valid in the next cycle.
					cmd_q.finish <= 1'b1;
					cmd_q.kind   <= FK_READ;
					state_q      <= FIN;
				end
				SWEEP: begin
					if (stat.done) begin
						if (!add_q) begin
							cmd_q.finish <= 1'b1;
							cmd_q.kind   <= stat.match ? FK_REM_OK : FK_REM_NF;
							state_q      <= FIN;
						end else if (stat.match) begin
							cmd_q.finish <= 1'b1;
							cmd_q.kind   <= FK_ADD_UPD;
							state_q      <= FIN;
						end else if (!stat.free) begin
							cmd_q.finish <= 1'b1;
							cmd_q.kind   <= FK_FULL;
							state_q      <= FIN;
						end else if (stat.base_zero || !stat.taken || stat.cand_max) begin
							cmd_q.finish <= 1'b1;
							cmd_q.kind   <= FK_ADD_NEW;
							state_q      <= FIN;
						end else begin
							// Candidate id is held by some entry: try the next one.
							cmd_q.sweep_start <= 1'b1;
							cmd_q.cand_inc    <= 1'b1;
						end
					end
				end
				FIN: begin
					busy_q  <= 1'b0;
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/krid_datapath.sv
`timescale 1ns / 1ps
// Datapath for the keyed roster: entry RAM, valid bits, sweep and result logic.
// Depends on krid_pkg and krid_ram; commanded by krid_ctrl.
module krid_datapath #(
	parameter int SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  krid_pkg::in_item_t   item,
	input  logic [7:0]           id_base,
	input  krid_pkg::dp_cmd_t    cmd,
	output krid_pkg::dp_status_t stat,
	output krid_pkg::out_item_t  result,
	output logic                 result_valid
);
	import krid_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	logic [ADDR_W-1:0] key_q;
	logic [2:0]        sel_q;
	logic [SLOTS-1:0]  valid_q;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     idx_q;
	logic              run_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic              done_q;
	logic              match_q, free_q, taken_q;
	logic [IW-1:0]     match_idx_q, free_idx_q;
	logic [ID_W-1:0]   match_id_q;
	logic [ID_W-1:0]   cand_q;
	out_item_t         result_q;
	logic              strobe_q;

	logic [IW-1:0]      sel_idx;
	logic               sel_in_range;
	logic [IW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ID_W-1:0]    rd_id;
	logic               ram_we;
	logic [ID_W-1:0]    new_id;
	logic               ent_valid;
	out_item_t          res_d;
	logic [CW-1:0]      cnt_d;

	assign sel_idx      = IW'(sel_q);
	assign sel_in_range = (32'(sel_q) < 32'(SLOTS));
	assign ram_raddr    = run_q ? idx_q : sel_idx;
	assign rd_addr      = ram_rdata[ENTRY_W-1:ID_W];
	assign rd_id        = ram_rdata[ID_W-1:0];
	assign ram_we       = cmd.finish && (cmd.kind == FK_ADD_NEW);
	assign ent_valid    = valid_q[idx_s1];

	// When every candidate from the base up is held, the base itself is reused.
	assign new_id = (id_base == '0) ? '0 : (taken_q ? id_base : cand_q);

	krid_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata({key_q, new_id}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_d = '0;
		cnt_d = cnt_q;
		case (cmd.kind)
			FK_ADD_UPD: begin
				res_d.assigned_id = match_id_q;
				res_d.slot_used   = 3'(match_idx_q);
			end
			FK_ADD_NEW: begin
				res_d.assigned_id = new_id;
				res_d.slot_used   = 3'(free_idx_q);
				res_d.newly_added = 1'b1;
				cnt_d             = cnt_q + CW'(1);
			end
			FK_FULL: begin
				res_d.status = ST_FULL;
			end
			FK_REM_OK: begin
				res_d.slot_used = 3'(match_idx_q);
				cnt_d           = cnt_q - CW'(1);
			end
			FK_REM_NF: begin
				res_d.status = ST_NOT_FOUND;
			end
			FK_CLEAR: begin
				cnt_d = '0;
			end
			FK_READ: begin
				res_d.slot_used = sel_q;
				if (sel_in_range && valid_q[sel_idx]) begin
					res_d.entry_present = 1'b1;
					res_d.assigned_id   = rd_id;
					res_d.entry_address = rd_addr;
				end
			end
			default: ;
		endcase
		res_d.entry_count = (32'(cnt_d) > 32'd15) ? 4'd15 : 4'(cnt_d);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= item.device_address;
			sel_q <= item.slot_select;
		end
		idx_s1 <= idx_q;
		if (cmd.cand_init) begin
			cand_q <= id_base;
		end else if (cmd.cand_inc) begin
			cand_q <= cand_q + 8'd1;
		end
		if (vld_s1 && !cmd.sweep_start) begin
			if (!match_q && ent_valid && rd_addr == key_q) begin
				match_idx_q <= idx_s1;
				match_id_q  <= rd_id;
			end
			if (!free_q && !ent_valid) begin
				free_idx_q <= idx_s1;
			end
		end
		if (cmd.finish) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
			run_q    <= 1'b0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
			match_q  <= 1'b0;
			free_q   <= 1'b0;
			taken_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1   <= run_q;
			done_q   <= vld_s1 && (idx_s1 == LAST);
			strobe_q <= cmd.finish;
			if (cmd.sweep_start) begin
				idx_q   <= '0;
				run_q   <= 1'b1;
				match_q <= 1'b0;
				free_q  <= 1'b0;
				taken_q <= 1'b0;
			end else begin
				if (run_q) begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST) begin
						run_q <= 1'b0;
					end
				end
				if (vld_s1) begin
					if (ent_valid && rd_addr == key_q) begin
						match_q <= 1'b1;
					end
					if (!ent_valid) begin
						free_q <= 1'b1;
					end
					if (ent_valid && rd_id == cand_q) begin
						taken_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				cnt_q <= cnt_d;
				case (cmd.kind)
					FK_ADD_NEW: valid_q[free_idx_q]  <= 1'b1;
					FK_REM_OK:  valid_q[match_idx_q] <= 1'b0;
					FK_CLEAR:   valid_q              <= '0;
					default: ;
				endcase
			end
		end
	end

	assign stat.done      = done_q;
	assign stat.match     = match_q;
	assign stat.free      = free_q;
	assign stat.taken     = taken_q;
	assign stat.cand_max  = (cand_q == 8'd255);
	assign stat.base_zero = (id_base == '0);

	assign result       = result_q;
	assign result_valid = strobe_q;

endmodule

FILE: src/keyed_roster_with_id_allocator.sv
`timescale 1ns / 1ps
// Keyed roster with id allocator. One command at a time; the result strobe comes with busy low.
// Clear and read use no sweep; remove runs one sweep of the table, and add runs one more for each
// held id it skips; each sweep reads the entry RAM once per slot.
// A new command may be accepted in the same cycle as the result strobe.
// Reset empties the table and sets id_base to 16; the receiver cannot stall results.
module keyed_roster_with_id_allocator #(
	parameter int SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  krid_pkg::in_item_t  command,
	output logic                result_valid,
	output krid_pkg::out_item_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import krid_pkg::*;

	logic       take;
	logic [7:0] id_base_q;
	dp_cmd_t    cmd;
	dp_status_t stat;

	assign take   = start && !busy;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ID_BASE) ? {24'd0, id_base_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= ID_BASE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ID_BASE) begin
			id_base_q <= pwdata[7:0];
		end
	end

	krid_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.op_in (command.operation),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	krid_datapath #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.item        (command),
		.id_base     (id_base_q),
		.cmd         (cmd),
		.stat        (stat),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule

FILE: verif/tb_keyed_roster_with_id_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_roster_with_id_allocator: directed table, then random phases.
// Each accepted command is run through a behavioral roster model; depends on krid_pkg and the DUT.
module tb_keyed_roster_with_id_allocator;
	import krid_pkg::*;

	localparam int SLOTS = 8;
	localparam int LIMIT = 600000;
	localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

	typedef struct {
		in_item_t  cmd;
		bit        pinned;
		out_item_t res;
	} row_t;

	typedef struct {
		bit        pinned;
		out_item_t res;
	} note_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    command = '0;
	logic        result_valid;
	out_item_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Roster model state, advanced at each accepted command.
	bit              roster_valid [SLOTS];
	logic [ADDR_W-1:0] roster_addr [SLOTS];
	logic [ID_W-1:0] roster_id [SLOTS];
	logic [ID_W-1:0] id_base_q = ID_BASE_RESET;

	out_item_t awaited_results [$];
	note_t     pinned_q [$];
	int        fail_count = 0;
	int        cycle_count = 0;
	int        burst_left = 0;

	keyed_roster_with_id_allocator #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int live_entries();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (roster_valid[i])
				n++;
		return (n > 15) ? 15 : n;
	endfunction

	function automatic logic [ID_W-1:0] next_free_id();
		bit held;
		if (id_base_q == 0)
			return '0;
		for (int id = id_base_q; id <= 255; id++) begin
			held = 0;
			for (int i = 0; i < SLOTS; i++)
				if (roster_valid[i] && roster_id[i] == id)
					held = 1;
			if (!held)
				return ID_W'(id);
		end
		return id_base_q;
	endfunction

	function automatic out_item_t roster_apply(in_item_t c);
		out_item_t r;
		int hit;
		int fr;
		r = '0;
		hit = -1;
		fr = -1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (roster_valid[i] && roster_addr[i] == c.device_address)
				hit = i;
			if (!roster_valid[i])
				fr = i;
		end
		case (c.operation)
			OP_ADD: begin
				if (hit >= 0) begin
					r.assigned_id = roster_id[hit];
					r.slot_used = 3'(hit);
				end else if (fr < 0) begin
					r.status = ST_FULL;
				end else begin
					r.assigned_id = next_free_id();
					roster_addr[fr] = c.device_address;
					roster_id[fr] = r.assigned_id;
					roster_valid[fr] = 1;
					r.slot_used = 3'(fr);
					r.newly_added = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					roster_valid[hit] = 0;
					roster_addr[hit] = '0;
					roster_id[hit] = '0;
					r.slot_used = 3'(hit);
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					roster_valid[i] = 0;
					roster_addr[i] = '0;
					roster_id[i] = '0;
				end
			end
			default: begin
				r.slot_used = c.slot_select;
				if (c.slot_select < SLOTS && roster_valid[c.slot_select]) begin
					r.entry_present = 1'b1;
					r.assigned_id = roster_id[c.slot_select];
					r.entry_address = roster_addr[c.slot_select];
				end
			end
		endcase
		r.entry_count = 4'(live_entries());
		return r;
	endfunction

	task automatic field_check(string name, logic [ADDR_W-1:0] e, logic [ADDR_W-1:0] a);
		if (a !== e) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			fail_count++;
		end
	endtask

	// Results are checked before the command accepted at the same edge is modeled.
	always @(posedge clk) begin
		out_item_t e;
		note_t n;
		if (arst_n) begin
			if (result_valid === 1'b1) begin
				if (awaited_results.size() == 0) begin
					$error("result: none expected, got %h", result);
					fail_count++;
				end else begin
					e = awaited_results.pop_front();
					field_check("status", ADDR_W'(e.status), ADDR_W'(result.status));
					field_check("assigned_id", ADDR_W'(e.assigned_id),
						ADDR_W'(result.assigned_id));
					field_check("slot_used", ADDR_W'(e.slot_used), ADDR_W'(result.slot_used));
					field_check("newly_added", ADDR_W'(e.newly_added),
						ADDR_W'(result.newly_added));
					field_check("entry_present", ADDR_W'(e.entry_present),
						ADDR_W'(result.entry_present));
					field_check("entry_address", e.entry_address, result.entry_address);
					field_check("entry_count", ADDR_W'(e.entry_count),
						ADDR_W'(result.entry_count));
				end
			end
			if (start && busy === 1'b0) begin
				n = pinned_q.pop_front();
				e = roster_apply(command);
				awaited_results.push_back(n.pinned ? n.res : e);
			end
		end
	end

	function automatic in_item_t mk_cmd(logic [1:0] op, logic [ADDR_W-1:0] a, logic [2:0] sel);
		in_item_t c;
		c.operation = op;
		c.device_address = a;
		c.slot_select = sel;
		return c;
	endfunction

	function automatic out_item_t mk_res(logic [1:0] st, logic [7:0] id, logic [2:0] slot,
			logic fresh, logic present, logic [ADDR_W-1:0] a, logic [3:0] cnt);
		out_item_t r;
		r.status = st;
		r.assigned_id = id;
		r.slot_used = slot;
		r.newly_added = fresh;
		r.entry_present = present;
		r.entry_address = a;
		r.entry_count = cnt;
		return r;
	endfunction

	// The sender runs in bursts; a gap drops start for a random stretch between them.
	task automatic send_item(in_item_t c, bit pinned, out_item_t res);
		note_t n;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		n.pinned = pinned;
		n.res = res;
		pinned_q.push_back(n);
		start <= 1'b1;
		command <= c;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// One edge first, so that the item accepted at the last edge is already awaited.
	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_id_base(logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_ID_BASE, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		id_base_q = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		field_check("id_base readback", ADDR_W'(val), ADDR_W'(prdata[7:0]));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		row_t rows [$];
		logic [ADDR_W-1:0] pool [12];
		logic [7:0] bases [8];
		logic [63:0] w;
		in_item_t c;
		int pick;

		for (int i = 0; i < SLOTS; i++) begin
			roster_valid[i] = 0;
			roster_addr[i] = '0;
			roster_id[i] = '0;
		end

		// After reset: empty table, id_base 16.
		rows.push_back('{mk_cmd(OP_REMOVE, '0, 3'd7), 1, mk_res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_cmd(OP_CLEAR, ADDR_ONES, 3'd5), 1, mk_res(ST_OK, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_cmd(OP_ADD, '0, 3'd0), 1, mk_res(ST_OK, 16, 0, 1, 0, 0, 1)});
		rows.push_back('{mk_cmd(OP_ADD, ADDR_ONES, 3'd7), 1, mk_res(ST_OK, 17, 1, 1, 0, 0, 2)});
		rows.push_back('{mk_cmd(OP_ADD, '0, 3'd2), 1, mk_res(ST_OK, 16, 0, 0, 0, 0, 2)});
		rows.push_back('{mk_cmd(OP_READ, ADDR_ONES, 3'd0), 1, mk_res(ST_OK, 16, 0, 0, 1, 0, 2)});
		rows.push_back('{mk_cmd(OP_READ, '0, 3'd1), 1,
			mk_res(ST_OK, 17, 1, 0, 1, ADDR_ONES, 2)});
		rows.push_back('{mk_cmd(OP_REMOVE, '0, 3'd3), 1, mk_res(ST_OK, 0, 0, 0, 0, 0, 1)});
		rows.push_back('{mk_cmd(OP_READ, '0, 3'd0), 1, mk_res(ST_OK, 0, 0, 0, 0, 0, 1)});
		rows.push_back('{mk_cmd(OP_ADD, 48'hAAAA_AAAA_AAAA, 3'd6), 1,
			mk_res(ST_OK, 16, 0, 1, 0, 0, 2)});
		rows.push_back('{mk_cmd(OP_ADD, 48'h5555_5555_5555, 3'd1), 0, '0});
		rows.push_back('{mk_cmd(OP_ADD, 48'h0000_0000_0001, 3'd4), 0, '0});
		rows.push_back('{mk_cmd(OP_ADD, 48'h8000_0000_0000, 3'd0), 0, '0});
		rows.push_back('{mk_cmd(OP_ADD, 48'h7FFF_FFFF_FFFF, 3'd3), 0, '0});
		rows.push_back('{mk_cmd(OP_ADD, 48'h0123_4567_89AB, 3'd2), 0, '0});
		rows.push_back('{mk_cmd(OP_ADD, 48'hFEDC_BA98_7654, 3'd5), 0, '0});
		// Table now full.
		rows.push_back('{mk_cmd(OP_ADD, '0, 3'd7), 1, mk_res(ST_FULL, 0, 0, 0, 0, 0, 8)});
		rows.push_back('{mk_cmd(OP_ADD, ADDR_ONES, 3'd0), 0, '0});
		rows.push_back('{mk_cmd(OP_REMOVE, '0, 3'd0), 1, mk_res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 8)});
		rows.push_back('{mk_cmd(OP_READ, '0, 3'd7), 0, '0});
		rows.push_back('{mk_cmd(OP_REMOVE, ADDR_ONES, 3'd2), 0, '0});
		rows.push_back('{mk_cmd(OP_ADD, '0, 3'd1), 0, '0});
		rows.push_back('{mk_cmd(OP_CLEAR, 48'h0F0F_0F0F_0F0F, 3'd6), 1,
			mk_res(ST_OK, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_cmd(OP_READ, ADDR_ONES, 3'd7), 1, mk_res(ST_OK, 0, 7, 0, 0, 0, 0)});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].cmd, rows[i].pinned, rows[i].res);

		// High bases run the ids out with free slots left; zero base has no candidate id.
		bases = '{8'd255, 8'd1, 8'd0, 8'd250, 8'd128, 8'd16, 8'd248, 8'($urandom_range(1, 255))};
		foreach (bases[p]) begin
			drain();
			set_id_base(bases[p]);
			pool[0] = '0;
			pool[1] = ADDR_ONES;
			for (int k = 2; k < 12; k++) begin
				w = {$urandom, $urandom};
				pool[k] = w[ADDR_W-1:0];
			end
			for (int n = 0; n < 104; n++) begin
				pick = $urandom_range(0, 99);
				w = {$urandom, $urandom};
				c.device_address = ($urandom_range(0, 6) == 0) ? w[ADDR_W-1:0]
					: pool[$urandom_range(0, 11)];
				c.slot_select = 3'($urandom_range(0, 7));
				if (pick < 45)
					c.operation = OP_ADD;
				else if (pick < 76)
					c.operation = OP_REMOVE;
				else if (pick < 96)
					c.operation = OP_READ;
				else
					c.operation = OP_CLEAR;
				send_item(c, 0, '0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
